// ===== rtl/fmcvs_pkg.sv =====
// Shared types, codes and level helpers for the FM carrier volume shim.
package fmcvs_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int CH_W             = 3;
    localparam int SLOT_W           = 5;
    localparam int NUM_SLOTS        = 32;
    localparam int NUM_CH_MAX       = 8;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_MUTE   = 2'd1;
    localparam logic [1:0] OP_UNMUTE = 2'd2;

    localparam logic       CFG_VOLUME  = 1'b0;
    localparam logic       CFG_PRESENT = 1'b1;

    localparam logic signed [7:0] VOLUME_RESET = -8'sd12;
    localparam logic signed [7:0] MUTE_OFFSET  = -8'sd127;
    localparam logic [7:0]        LEVEL_RESET  = 8'h7f;
    localparam logic [2:0]        TL_PREFIX    = 3'b011;
    localparam logic [4:0]        ALGO_PREFIX  = 5'b00100;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_addr;
        logic [7:0] out_data;
        logic       last;
    } res_t;

    typedef struct packed {
        logic            load;
        logic            upd_mask;
        logic            resend;
        logic            emit_write;
        logic            flush;
        logic [CH_W-1:0] ch;
        logic [1:0]      k;
    } ctrl_t;

    typedef struct packed {
        logic       chip_present;
        logic [1:0] op;
        logic       is_algo;
        logic       mask_changes;
    } sts_t;

    function automatic logic [3:0] algo_carriers(input logic [2:0] algo);
        logic [3:0] m;
        case (algo)
            3'd0, 3'd1, 3'd2, 3'd3: m = 4'h8;
            3'd4:                   m = 4'hc;
            3'd5, 3'd6:             m = 4'he;
            3'd7:                   m = 4'hf;
            default:                m = 4'h8;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] adjust_level(input logic [7:0] level,
                                                input logic signed [7:0] v);
        logic [9:0] t;
        logic [7:0] r;
        t = {3'b000, level[6:0]} - {{2{v[7]}}, v};
        if (t[9])
            r = 8'h00;
        else if (t[8:7] != 2'b00)
            r = LEVEL_RESET;
        else
            r = {1'b0, t[6:0]};
        return r;
    endfunction

endpackage

// ===== rtl/fm_opm_carrier_volume_shim_core.sv =====
// Top level of the FM carrier volume shim: sequencer plus datapath.
// Plain write: decode, then flush; its beat passes through the pending and output registers.
// Algorithm change: four slot checks of one channel, then the write.
// Mute/unmute: the walk checks every slot of all NUM_CHANNELS channels, one slot per cycle.
// One beat per cycle at most; res_valid marks each beat for one cycle only.
// rst_n clears control, restores volume -12, chip present, levels 0x7f, masks 0.
module fm_opm_carrier_volume_shim_core
    import fmcvs_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  cmd_t       cmd,
    output logic       res_valid,
    output res_t       res,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    ctrl_t      ctrl;
    sts_t       sts;
    logic [7:0] cur_addr;

    fmcvs_ctrl #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .reg_addr (cur_addr),
        .sts      (sts),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    fmcvs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .sts       (sts),
        .cur_addr  (cur_addr),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

// ===== rtl/fmcvs_ctrl.sv =====
// Sequencer for the FM carrier volume shim: decode, slot walk and flush.
module fmcvs_ctrl
    import fmcvs_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  [7:0] reg_addr,
    input  sts_t  sts,
    output ctrl_t ctrl,
    output logic  busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    logic [2:0]      state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic [1:0]      k_reg, k_next;
    logic            all_reg, all_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            k_reg     <= '0;
            all_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            k_reg     <= k_next;
            all_reg   <= all_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        k_next     = k_reg;
        all_next   = all_reg;
        ctrl       = '0;
        ctrl.ch    = ch_reg;
        ctrl.k     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                k_next = 2'd0;
                if (!sts.chip_present)
                    state_next = S_IDLE;
                else if (sts.op == OP_WRITE)
                begin
                    if (sts.is_algo && sts.mask_changes)
                    begin
                        ctrl.upd_mask = 1'b1;
                        ch_next       = reg_addr[CH_W-1:0];
                        all_next      = 1'b0;
                        state_next    = S_WALK;
                    end
                    else
                    begin
                        ctrl.emit_write = 1'b1;
                        state_next      = S_FLUSH;
                    end
                end
                else if (sts.op == OP_MUTE || sts.op == OP_UNMUTE)
                begin
                    ch_next    = '0;
                    all_next   = 1'b1;
                    state_next = S_WALK;
                end
                else
                    state_next = S_IDLE;
            end
            S_WALK:
            begin
                ctrl.resend = 1'b1;
                k_next      = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    if (!all_reg)
                        state_next = S_EMIT;
                    else if (ch_reg == LAST_CH)
                        state_next = S_FLUSH;
                    else
                        ch_next = ch_reg + CH_W'(1);
                end
            end
            S_EMIT:
            begin
                ctrl.emit_write = 1'b1;
                state_next      = S_FLUSH;
            end
            S_FLUSH:
            begin
                ctrl.flush = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/fmcvs_dp.sv =====
// Datapath for the FM carrier volume shim: shadows, masks, level math, output beat.
module fmcvs_dp
    import fmcvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  ctrl_t      ctrl,
    output sts_t       sts,
    output logic [7:0] cur_addr,
    output logic       res_valid,
    output res_t       res
);

    cmd_t              cmd_reg;
    logic signed [7:0] volume_reg;
    logic              present_reg;
    logic [7:0]        shadow_reg [NUM_SLOTS];
    logic [3:0]        mask_reg [NUM_CH_MAX];
    res_t              pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    res_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic              is_tl;
    logic [3:0]        new_mask;
    logic              tl_carrier;
    logic [SLOT_W-1:0] slot;
    logic signed [7:0] walk_v;
    logic              gen;
    res_t              gen_beat;

    assign is_tl      = (cmd_reg.reg_addr[7:5] == TL_PREFIX);
    assign new_mask   = algo_carriers(cmd_reg.reg_data[2:0]);
    assign tl_carrier = mask_reg[cmd_reg.reg_addr[2:0]][cmd_reg.reg_addr[4:3]];
    assign slot       = {ctrl.k, ctrl.ch};
    assign walk_v     = (cmd_reg.op == OP_MUTE) ? MUTE_OFFSET : volume_reg;

    assign sts.chip_present = present_reg;
    assign sts.op           = cmd_reg.op;
    assign sts.is_algo      = (cmd_reg.reg_addr[7:3] == ALGO_PREFIX);
    assign sts.mask_changes = (mask_reg[cmd_reg.reg_addr[2:0]] != new_mask);
    assign cur_addr         = cmd_reg.reg_addr;

    always_comb
    begin
        gen      = 1'b0;
        gen_beat = '0;
        if (ctrl.resend && mask_reg[ctrl.ch][ctrl.k])
        begin
            gen               = 1'b1;
            gen_beat.out_addr = {TL_PREFIX, slot};
            gen_beat.out_data = adjust_level(shadow_reg[slot], walk_v);
        end
        else if (ctrl.emit_write)
        begin
            gen               = 1'b1;
            gen_beat.out_addr = cmd_reg.reg_addr;
            gen_beat.out_data = (is_tl && tl_carrier)
                              ? adjust_level(cmd_reg.reg_data, volume_reg)
                              : cmd_reg.reg_data;
        end
    end

    // hold one beat back so the final one can carry last
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        res_next        = res_reg;
        res_valid_next  = 1'b0;
        if (gen)
        begin
            res_next        = pend_reg;
            res_next.last   = 1'b0;
            res_valid_next  = pend_valid_reg;
            pend_next       = gen_beat;
            pend_valid_next = 1'b1;
        end
        else if (ctrl.flush)
        begin
            res_next        = pend_reg;
            res_next.last   = 1'b1;
            res_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            cmd_reg <= cmd;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg     <= VOLUME_RESET;
            present_reg    <= 1'b1;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
                shadow_reg[i] <= LEVEL_RESET;
            for (int i = 0; i < NUM_CH_MAX; i++)
                mask_reg[i] <= 4'h0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we && cfg_index == CFG_VOLUME)
                volume_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_PRESENT)
                present_reg <= cfg_data[0];
            if (ctrl.emit_write && is_tl)
                shadow_reg[cmd_reg.reg_addr[4:0]] <= cmd_reg.reg_data;
            if (ctrl.upd_mask)
                mask_reg[cmd_reg.reg_addr[2:0]] <= new_mask;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== dv/fm_opm_carrier_volume_shim_core_test.sv =====
// Self-checking testbench for the FM carrier volume shim: directed table, then random commands.
module fm_opm_carrier_volume_shim_core_test;
    import fmcvs_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         TB_CHANNELS = NUM_CHANNELS_DEF;
    localparam int         IDLE_PAUSE  = 40;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         NUM_PHASES  = 9;
    localparam int         PHASE_CMDS  = 35;
    localparam logic [3:0] ALGO_MASK_TBL [8] = '{4'h8, 4'h8, 4'h8, 4'h8,
                                                 4'hc, 4'he, 4'he, 4'hf};

    typedef struct {
        cmd_t c;
        bit   typed;
        res_t wr;
    } dir_row_t;

    localparam int NUM_DIR = 22;
    dir_row_t dir_rows [NUM_DIR] = '{
        '{cmd_t'({OP_WRITE,  8'h60, 8'h50}), 1'b1, res_t'({8'h60, 8'h50, 1'b1})},
        '{cmd_t'({OP_WRITE,  8'h00, 8'h00}), 1'b1, res_t'({8'h00, 8'h00, 1'b1})},
        '{cmd_t'({OP_WRITE,  8'hff, 8'hff}), 1'b1, res_t'({8'hff, 8'hff, 1'b1})},
        '{cmd_t'({OP_MUTE,   8'h00, 8'h00}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_UNUSED, 8'h00, 8'h00}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_UNMUTE, 8'h00, 8'h00}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_WRITE,  8'h20, 8'h07}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_WRITE,  8'h60, 8'h00}), 1'b1, res_t'({8'h60, 8'h0c, 1'b1})},
        '{cmd_t'({OP_WRITE,  8'h78, 8'hff}), 1'b1, res_t'({8'h78, 8'h7f, 1'b1})},
        '{cmd_t'({OP_WRITE,  8'h20, 8'h0f}), 1'b1, res_t'({8'h20, 8'h0f, 1'b1})},
        '{cmd_t'({OP_WRITE,  8'h27, 8'h04}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_WRITE,  8'h23, 8'h00}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_MUTE,   8'h00, 8'h00}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_UNMUTE, 8'hff, 8'hff}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_WRITE,  8'h7f, 8'h80}), 1'b1, res_t'({8'h7f, 8'h0c, 1'b1})},
        '{cmd_t'({OP_WRITE,  8'h28, 8'h12}), 1'b1, res_t'({8'h28, 8'h12, 1'b1})},
        '{cmd_t'({OP_WRITE,  8'h5f, 8'haa}), 1'b1, res_t'({8'h5f, 8'haa, 1'b1})},
        '{cmd_t'({OP_WRITE,  8'h80, 8'h55}), 1'b1, res_t'({8'h80, 8'h55, 1'b1})},
        '{cmd_t'({OP_UNUSED, 8'hff, 8'hff}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_WRITE,  8'h24, 8'h05}), 1'b0, res_t'('0)},
        '{cmd_t'({OP_WRITE,  8'h24, 8'h06}), 1'b1, res_t'({8'h24, 8'h06, 1'b1})},
        '{cmd_t'({OP_UNMUTE, 8'h00, 8'h00}), 1'b0, res_t'('0)}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    cmd_t       cmd = '0;
    logic       res_valid;
    res_t       res;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_VOLUME;
    logic [7:0] cfg_data = 8'h00;

    logic [7:0]        level_shadow [32];
    logic [3:0]        carrier_bits [8];
    logic signed [7:0] volume;
    logic              chip_on;

    res_t pending_writes [$];
    res_t want;
    int   mismatches = 0;
    int   beats_seen = 0;
    int   cmds_sent = 0;
    int   cycles = 0;
    bit   gapless = 1'b0;

    fm_opm_carrier_volume_shim_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fm_opm_carrier_volume_shim_core: mismatch");
            $finish;
        end
    end

    function automatic logic [7:0] carrier_level(input logic [7:0] lv, input int v);
        int t;
        t = int'(lv[6:0]) - v;
        if (t < 0)
            t = 0;
        if (t > 127)
            t = 127;
        return t[7:0];
    endfunction

    function automatic void resend_channel(input int ch, input int v, ref res_t wr [$]);
        int slot;
        for (int k = 0; k < 4; k++)
        begin
            slot = ch + 8 * k;
            if (carrier_bits[ch][k])
                wr.push_back(res_t'({8'h60 + 8'(slot),
                                     carrier_level(level_shadow[slot], v), 1'b0}));
        end
    endfunction

    function automatic void shim_writes_for(input cmd_t c, ref res_t wr [$]);
        logic [7:0] data;
        logic [2:0] ch;
        wr.delete();
        if (!chip_on)
            return;
        data = c.reg_data;
        ch = c.reg_addr[2:0];
        case (c.op)
            OP_WRITE:
            begin
                if (c.reg_addr[7:5] == TL_PREFIX)
                begin
                    level_shadow[c.reg_addr[4:0]] = c.reg_data;
                    if (carrier_bits[ch][c.reg_addr[4:3]])
                        data = carrier_level(c.reg_data, int'(volume));
                end
                else if (c.reg_addr[7:3] == ALGO_PREFIX)
                begin
                    if (carrier_bits[ch] != ALGO_MASK_TBL[c.reg_data[2:0]])
                    begin
                        carrier_bits[ch] = ALGO_MASK_TBL[c.reg_data[2:0]];
                        resend_channel(int'(ch), int'(volume), wr);
                    end
                end
                wr.push_back(res_t'({c.reg_addr, data, 1'b0}));
            end
            OP_MUTE, OP_UNMUTE:
            begin
                for (int i = 0; i < TB_CHANNELS; i++)
                    resend_channel(i, (c.op == OP_MUTE) ? -127 : int'(volume), wr);
            end
            default: ;
        endcase
        if (wr.size() > 0)
            wr[wr.size() - 1].last = 1'b1;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   r;
        r = $urandom_range(0, 99);
        c.op = OP_WRITE;
        c.reg_addr = 8'($urandom_range(0, 255));
        c.reg_data = 8'($urandom_range(0, 255));
        if (r < 45)
            c.reg_addr[7:5] = TL_PREFIX;
        else if (r < 65)
            c.reg_addr[7:3] = ALGO_PREFIX;
        else if (r < 74)
            c.op = OP_MUTE;
        else if (r < 86)
            c.op = OP_UNMUTE;
        else if (r >= 95)
            c.op = OP_UNUSED;
        return c;
    endfunction

    task automatic note_mismatch(input string what, input res_t e, input res_t a);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected addr %h data %h last %b, got addr %h data %h last %b",
                     what, e.out_addr, e.out_data, e.last, a.out_addr, a.out_data, a.last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid)
        begin
            beats_seen++;
            if (pending_writes.size() == 0)
                note_mismatch("unexpected beat", res_t'('0), res);
            else
            begin
                want = pending_writes.pop_front();
                if (want.out_addr !== res.out_addr || want.out_data !== res.out_data
                    || want.last !== res.last)
                    note_mismatch("wrong beat", want, res);
            end
        end
    end

    task automatic apply_cmd(input cmd_t c, input bit typed, input res_t typed_wr);
        int   gap;
        res_t wr [$];
        gap = gapless ? 0 : idle_len();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        cmds_sent++;
        shim_writes_for(c, wr);
        if (typed)
            pending_writes.push_back(typed_wr);
        else
            foreach (wr[i])
                pending_writes.push_back(wr[i]);
    endtask

    task automatic set_reg(input logic idx, input logic [7:0] val);
        start <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_VOLUME)
            volume = val;
        else
            chip_on = val[0];
    endtask

    initial
    begin
        int         vols [NUM_PHASES];
        bit         present [NUM_PHASES];
        logic [7:0] vol_byte;
        foreach (level_shadow[i])
            level_shadow[i] = LEVEL_RESET;
        foreach (carrier_bits[i])
            carrier_bits[i] = 4'h0;
        volume = VOLUME_RESET;
        chip_on = 1'b1;
        vols = '{-128, 127, -127, 0, 0, 0, 0, 1, -12};
        present = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            apply_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].wr);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            vol_byte = (p >= 4 && p <= 6) ? 8'($urandom_range(0, 255)) : 8'(vols[p]);
            set_reg(CFG_VOLUME, vol_byte);
            set_reg(CFG_PRESENT, {7'd0, present[p]});
            gapless = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_CMDS; n++)
                apply_cmd(rand_cmd(), 1'b0, res_t'('0));
        end

        start <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);

        $display("%0d commands accepted, %0d chip writes checked over %0d register settings",
                 cmds_sent, beats_seen, NUM_PHASES + 1);
        $display("volume extremes -128, -127, 0, 127 and chip absent were exercised");
        if (mismatches == 0)
            $display("fm_opm_carrier_volume_shim_core: match");
        else
            $display("fm_opm_carrier_volume_shim_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fmcvs_pkg.sv
rtl/fmcvs_ctrl.sv
rtl/fmcvs_dp.sv
rtl/fm_opm_carrier_volume_shim_core.sv
dv/fm_opm_carrier_volume_shim_core_test.sv
